### rtl/mgof_pkg.sv
// ----------------------------------------------------------------------------
// mgof_pkg
// Shared constants, register map and integer square root for the glow outline
// filter.
// ----------------------------------------------------------------------------
package mgof_pkg;

    localparam int DEF_MAX_WIDTH        = 64;
    localparam int DEF_MAX_HEIGHT       = 64;
    localparam int DEF_MAX_RADIUS       = 8;
    localparam int DEF_WEIGHT_FRAC_BITS = 12;

    localparam int COORD_W  = 7;   // column / row field width
    localparam int DIST_W   = 5;   // |dx|, |dy| up to 31
    localparam int CHAN_W   = 8;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] REG_MASK_WIDTH  = 3'd0;
    localparam logic [2:0] REG_MASK_HEIGHT = 3'd1;
    localparam logic [2:0] REG_GLOW_RADIUS = 3'd2;
    localparam logic [2:0] REG_GLOW_RED    = 3'd3;
    localparam logic [2:0] REG_GLOW_GREEN  = 3'd4;
    localparam logic [2:0] REG_GLOW_BLUE   = 3'd5;

    localparam logic [6:0] RST_MASK_WIDTH  = 7'd64;
    localparam logic [6:0] RST_MASK_HEIGHT = 7'd64;
    localparam logic [3:0] RST_GLOW_RADIUS = 4'd4;
    localparam logic [7:0] RST_GLOW_CHAN   = 8'd255;

    typedef struct packed {
        logic              clear;
        logic              add;
        logic [DIST_W-1:0] adx;
        logic [DIST_W-1:0] ady;
    } t_acc_cmd;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

endpackage

### rtl/mgof_store.sv
// ----------------------------------------------------------------------------
// mgof_store
// Coverage bit memory, one sprite row per word, bit writes and registered
// row reads.
// ----------------------------------------------------------------------------
module mgof_store import mgof_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int RAW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int CAW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic           i_clk,
    input  logic           i_wr_en,
    input  logic [RAW-1:0] i_wr_row,
    input  logic [CAW-1:0] i_wr_col,
    input  logic           i_wr_bit,
    input  logic           i_rd_en,
    input  logic [RAW-1:0] i_rd_row,
    input  logic [CAW-1:0] i_sel_col,
    output logic           o_bit
);

    logic [MAX_WIDTH-1:0] r_mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row][i_wr_col] <= i_wr_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    assign o_bit = r_rd_data[i_sel_col];

endmodule

### rtl/mgof_accum.sv
// ----------------------------------------------------------------------------
// mgof_accum
// Shared weight lookup and saturating accumulator, one pixel per cycle.
// ----------------------------------------------------------------------------
module mgof_accum import mgof_pkg::*; #(
    parameter int MAX_RADIUS       = DEF_MAX_RADIUS,
    parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_acc_cmd          i_cmd,
    output logic [CHAN_W-1:0] o_alpha,
    output logic              o_covered
);

    localparam int TW = $clog2(MAX_RADIUS + 1);
    localparam int WW = WEIGHT_FRAC_BITS + 9;
    localparam int AW = WW + 1;
    localparam logic [AW-1:0] ACC_MAX = AW'(255) << WEIGHT_FRAC_BITS;
    localparam logic [63:0]   WEIGHT_K = 64'd765 << (WEIGHT_FRAC_BITS - 1);

    logic [WW-1:0] w_tab [MAX_RADIUS+1][MAX_RADIUS+1];
    logic [WW-1:0] c_w;
    logic [AW-1:0] c_sum;
    logic [AW-1:0] r_acc;
    logic [AW-1:0] n_acc;
    logic          r_any;
    logic          n_any;

    // floor(382.5 * 2^F / d2^1.5), 255 * 2^F at d2 = 0
    for (genvar ga = 0; ga <= MAX_RADIUS; ga++) begin : g_row
        for (genvar gb = 0; gb <= MAX_RADIUS; gb++) begin : g_col
            localparam logic [63:0] D2 = 64'(ga * ga + gb * gb);
            localparam logic [63:0] D3 = (D2 == 64'd0) ? 64'd1 : D2 * D2 * D2;
            localparam logic [63:0] QV = (WEIGHT_K * WEIGHT_K) / D3;
            localparam logic [63:0] WV = (D2 == 64'd0) ? (64'd255 << WEIGHT_FRAC_BITS)
                                                       : isqrt64(QV);
            assign w_tab[ga][gb] = WW'(WV);
        end
    end

    always_comb begin
        c_w   = w_tab[i_cmd.adx[TW-1:0]][i_cmd.ady[TW-1:0]];
        c_sum = r_acc + AW'(c_w);
        n_acc = r_acc;
        n_any = r_any;
        if (i_cmd.clear) begin
            n_acc = '0;
            n_any = 1'b0;
        end else if (i_cmd.add) begin
            n_acc = (c_sum > ACC_MAX) ? ACC_MAX : c_sum;
            n_any = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
        end else begin
            r_any <= n_any;
        end
    end

    // acc never exceeds 255 << F, so the integer part fits 8 bits
    assign o_alpha   = r_acc[WEIGHT_FRAC_BITS +: CHAN_W];
    assign o_covered = r_any;

endmodule

### rtl/mgof_seq.sv
// ----------------------------------------------------------------------------
// mgof_seq
// Sequencer: load decode, window clipping, row reads and pixel scan.
// ----------------------------------------------------------------------------
module mgof_seq import mgof_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    localparam int RAW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int CAW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_op,
    input  logic [COORD_W-1:0] i_col,
    input  logic [COORD_W-1:0] i_row,
    input  logic [CHAN_W-1:0]  i_src_alpha,
    input  logic [6:0]         i_mask_width,
    input  logic [6:0]         i_mask_height,
    input  logic [3:0]         i_glow_radius,
    input  logic               i_slot_free,
    input  logic               i_bit,
    output logic               o_ready,
    output logic               o_wr_en,
    output logic [RAW-1:0]     o_wr_row,
    output logic [CAW-1:0]     o_wr_col,
    output logic               o_wr_bit,
    output logic               o_rd_en,
    output logic [RAW-1:0]     o_rd_row,
    output logic [CAW-1:0]     o_sel_col,
    output t_acc_cmd           o_cmd,
    output logic               o_deliver
);

    localparam int DIM_A = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_B = (DIM_A > (1 << COORD_W)) ? DIM_A : (1 << COORD_W);
    localparam int SW    = $clog2(DIM_B + 2 * MAX_RADIUS + 1) + 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SETUP = 5'b00010,
        ST_READ  = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic signed [SW-1:0] c_w, c_h, c_r;
    logic signed [SW-1:0] c_x, c_y, c_x0, c_x1, c_y0, c_y1;
    logic signed [SW-1:0] c_dx, c_dy, c_adx, c_ady;
    logic signed [SW-1:0] c_in_col, c_in_row;

    logic [COORD_W-1:0]   r_col, r_row;
    logic signed [SW-1:0] r_x, r_y, r_x0, r_x1, r_y1;
    logic signed [SW-1:0] r_lx, r_ly;
    logic signed [SW-1:0] n_lx, n_ly;

    always_comb begin
        c_w = SW'(i_mask_width);
        if (c_w > SW'(MAX_WIDTH)) begin
            c_w = SW'(MAX_WIDTH);
        end
        c_h = SW'(i_mask_height);
        if (c_h > SW'(MAX_HEIGHT)) begin
            c_h = SW'(MAX_HEIGHT);
        end
        c_r = SW'(i_glow_radius);
        if (c_r > SW'(MAX_RADIUS)) begin
            c_r = SW'(MAX_RADIUS);
        end

        c_in_col = SW'(i_col);
        c_in_row = SW'(i_row);

        c_x  = SW'(r_col) - c_r;
        c_y  = SW'(r_row) - c_r;
        c_x0 = (c_x - c_r < 0) ? '0 : c_x - c_r;
        c_x1 = (c_x + c_r > c_w) ? c_w : c_x + c_r;
        c_y0 = (c_y - c_r < 0) ? '0 : c_y - c_r;
        c_y1 = (c_y + c_r > c_h) ? c_h : c_y + c_r;

        c_dx  = r_x - r_lx;
        c_dy  = r_y - r_ly;
        c_adx = (c_dx < 0) ? -c_dx : c_dx;
        c_ady = (c_dy < 0) ? -c_dy : c_dy;
    end

    // loads write straight through, no busy time
    assign o_wr_en  = i_accept && (i_op == OP_LOAD) && (c_in_col < c_w) && (c_in_row < c_h);
    assign o_wr_row = RAW'(i_row);
    assign o_wr_col = CAW'(i_col);
    assign o_wr_bit = (i_src_alpha != '0);

    assign o_ready   = (r_state == ST_IDLE);
    assign o_rd_row  = r_ly[RAW-1:0];
    assign o_sel_col = r_lx[CAW-1:0];

    always_comb begin
        n_state   = r_state;
        n_lx      = r_lx;
        n_ly      = r_ly;
        o_rd_en   = 1'b0;
        o_deliver = 1'b0;
        o_cmd     = '0;
        o_cmd.adx = DIST_W'(c_adx);
        o_cmd.ady = DIST_W'(c_ady);
        case (r_state)
            ST_IDLE: begin
                if (i_accept && (i_op == OP_QUERY)) begin
                    o_cmd.clear = 1'b1;
                    n_state     = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_ly = c_y0;
                if ((c_x0 >= c_x1) || (c_y0 >= c_y1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_rd_en = 1'b1;
                n_lx    = r_x0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.add = i_bit;
                if (r_lx == r_x1 - SW'(1)) begin
                    if (r_ly == r_y1 - SW'(1)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_ly    = r_ly + SW'(1);
                        n_state = ST_READ;
                    end
                end else begin
                    n_lx = r_lx + SW'(1);
                end
            end
            ST_DONE: begin
                if (i_slot_free) begin
                    o_deliver = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_col <= i_col;
            r_row <= i_row;
        end
        if (r_state == ST_SETUP) begin
            r_x  <= c_x;
            r_y  <= c_y;
            r_x0 <= c_x0;
            r_x1 <= c_x1;
            r_y1 <= c_y1;
        end
        r_lx <= n_lx;
        r_ly <= n_ly;
    end

endmodule

### rtl/mask_glow_outline_filter.sv
// ----------------------------------------------------------------------------
// mask_glow_outline_filter
// Glow outline filter over a one-bit sprite coverage mask.
// ----------------------------------------------------------------------------
// A load beat (tuser 0) writes one coverage bit; the block stays ready. A query
// beat (tuser 1) scans its clipped window one mask row at a time through a
// single weight lookup and saturating adder: a setup state, then per window row
// a row read followed by a scan of one column per cycle, then a hand-off of the
// result to the output register, and the idle state in which the next beat is
// taken. A full window spans 2R rows of 2R columns; an empty window skips the
// row reads and the scan. A stalled output register holds the hand-off until it
// is free. tready is low while a query is in flight.
module mask_glow_outline_filter import mgof_pkg::*; #(
    parameter int MAX_WIDTH        = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT       = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS       = DEF_MAX_RADIUS,
    parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // column[6:0], row[13:7], source_alpha[21:14]
    input  logic [0:0]        s_axis_tuser,   // operation[0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic [0:0]        m_axis_tuser,   // covered[0]
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int RAW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CAW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [6:0]        r_mask_width, r_mask_height;
    logic [3:0]        r_glow_radius;
    logic [CHAN_W-1:0] r_glow_red, r_glow_green, r_glow_blue;

    logic              r_m_valid;
    logic [31:0]       r_m_data;
    logic              r_m_user;

    logic              w_accept, w_cfg_wr, w_slot_free;
    logic              w_wr_en, w_wr_bit, w_rd_en, w_bit, w_deliver, w_covered;
    logic [RAW-1:0]    w_wr_row, w_rd_row;
    logic [CAW-1:0]    w_wr_col, w_sel_col;
    logic [CHAN_W-1:0] w_alpha;
    t_acc_cmd          w_cmd;
    logic [2:0]        w_reg_idx;

    assign pready      = 1'b1;
    assign w_reg_idx   = paddr[4:2];
    assign w_cfg_wr    = psel && penable && pwrite && pready;
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_slot_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_width  <= RST_MASK_WIDTH;
            r_mask_height <= RST_MASK_HEIGHT;
            r_glow_radius <= RST_GLOW_RADIUS;
            r_glow_red    <= RST_GLOW_CHAN;
            r_glow_green  <= RST_GLOW_CHAN;
            r_glow_blue   <= RST_GLOW_CHAN;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_MASK_WIDTH:  r_mask_width  <= pwdata[6:0];
                REG_MASK_HEIGHT: r_mask_height <= pwdata[6:0];
                REG_GLOW_RADIUS: r_glow_radius <= pwdata[3:0];
                REG_GLOW_RED:    r_glow_red    <= pwdata[7:0];
                REG_GLOW_GREEN:  r_glow_green  <= pwdata[7:0];
                REG_GLOW_BLUE:   r_glow_blue   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_MASK_WIDTH:  prdata = DATA_W'(r_mask_width);
            REG_MASK_HEIGHT: prdata = DATA_W'(r_mask_height);
            REG_GLOW_RADIUS: prdata = DATA_W'(r_glow_radius);
            REG_GLOW_RED:    prdata = DATA_W'(r_glow_red);
            REG_GLOW_GREEN:  prdata = DATA_W'(r_glow_green);
            REG_GLOW_BLUE:   prdata = DATA_W'(r_glow_blue);
            default:         prdata = '0;
        endcase
    end

    mgof_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_op          (s_axis_tuser[0]),
        .i_col         (s_axis_tdata[6:0]),
        .i_row         (s_axis_tdata[13:7]),
        .i_src_alpha   (s_axis_tdata[21:14]),
        .i_mask_width  (r_mask_width),
        .i_mask_height (r_mask_height),
        .i_glow_radius (r_glow_radius),
        .i_slot_free   (w_slot_free),
        .i_bit         (w_bit),
        .o_ready       (s_axis_tready),
        .o_wr_en       (w_wr_en),
        .o_wr_row      (w_wr_row),
        .o_wr_col      (w_wr_col),
        .o_wr_bit      (w_wr_bit),
        .o_rd_en       (w_rd_en),
        .o_rd_row      (w_rd_row),
        .o_sel_col     (w_sel_col),
        .o_cmd         (w_cmd),
        .o_deliver     (w_deliver)
    );

    mgof_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_row  (w_wr_row),
        .i_wr_col  (w_wr_col),
        .i_wr_bit  (w_wr_bit),
        .i_rd_en   (w_rd_en),
        .i_rd_row  (w_rd_row),
        .i_sel_col (w_sel_col),
        .o_bit     (w_bit)
    );

    mgof_accum #(
        .MAX_RADIUS       (MAX_RADIUS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_alpha   (w_alpha),
        .o_covered (w_covered)
    );

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_deliver) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_deliver) begin
            r_m_user <= w_covered;
            r_m_data <= w_covered ? {w_alpha, r_glow_blue, r_glow_green, r_glow_red} : '0;
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_data;
    assign m_axis_tuser[0] = r_m_user;

endmodule

### rtl/mgof_checker.sv
// ----------------------------------------------------------------------------
// mgof_checker
// Port-level checks for the glow outline filter, bound to the top level.
// ----------------------------------------------------------------------------
module mgof_checker import mgof_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [23:0]       s_axis_tdata,
    input logic [0:0]        s_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [31:0]       m_axis_tdata,
    input logic [0:0]        m_axis_tuser,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata,
    input logic              pready
);

    logic w_unused;
    assign w_unused = ^{s_axis_tdata, psel, penable, pwrite, paddr, pwdata, prdata, pready};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output beat changed while stalled");

    a_uncovered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 32'd0))
        else $error("uncovered beat carries nonzero data");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_QUERY)) |=> !s_axis_tready)
        else $error("ready stayed high after a query");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_LOAD)) |=> s_axis_tready)
        else $error("load beat stalled the input");

endmodule

bind mask_glow_outline_filter mgof_checker u_mgof_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
);
